### rtl/svs_pkg.sv
// Shared types, constants and fixed-point helpers for the skinning block.
package svs_pkg;

  localparam int MAX_JOINTS_DEF = 64;
  localparam int JT_W = 224;   // joint entry: pos x,y,z then quat x,y,z,w

  typedef enum logic [1:0] {
    OP_JOINT  = 2'd0,
    OP_START  = 2'd1,
    OP_WEIGHT = 2'd2,
    OP_FINAL  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_X0  = 4'd0,
    ST_X1  = 4'd1,
    ST_T   = 4'd2,
    ST_Y0  = 4'd3,
    ST_Y1  = 4'd4,
    ST_C   = 4'd5,
    ST_SUM = 4'd6,
    ST_MUL = 4'd7,
    ST_ACC = 4'd8
  } step_t;

  localparam logic [3:0] LAST_STEP = 4'd8;
  localparam logic [1:0] LAST_VEC  = 2'd3;

  typedef struct packed {
    op_t                operation;
    logic [5:0]         joint_index;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
    logic signed [31:0] vec_c_x;
    logic signed [31:0] vec_c_y;
    logic signed [31:0] vec_c_z;
    logic signed [31:0] scalar_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
    logic signed [31:0] bitan_x;
    logic signed [31:0] bitan_y;
    logic signed [31:0] bitan_z;
  } out_t;

  typedef struct packed {
    logic       run;
    step_t      step;
    logic [1:0] vsel;
    logic       item_load;
    logic       joint_load;
    logic       basis_load;
    logic       joint_write;
    logic       out_load;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -36'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // round half up, arithmetic shift, saturate
  function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + 64'sd32768) >>> 16;
    if (s > 64'sd2147483647) qmul = 32'sh7fffffff;
    else if (s < -64'sd2147483648) qmul = 32'sh80000000;
    else qmul = s[31:0];
  endfunction

  function automatic logic signed [31:0] sat48to32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) sat48to32 = 32'sh7fffffff;
    else if (v < -48'sd2147483648) sat48to32 = 32'sh80000000;
    else sat48to32 = v[31:0];
  endfunction

endpackage

### rtl/svs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/svs_ctrl.sv
// Controller: item dispatch, per-vector step sequencing and output handshake.
module svs_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  svs_pkg::op_t in_op,
  output logic         out_valid,
  input  logic         out_ready,
  output svs_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE, S_LOAD, S_RUN, S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] vec_r, vec_nxt;
  logic       final_r, final_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    vec_nxt       = vec_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.step      = svs_pkg::step_t'(step_r);
    cmd.vsel      = vec_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            svs_pkg::OP_JOINT: cmd.joint_write = 1'b1;
            svs_pkg::OP_START: cmd.basis_load  = 1'b1;
            default: begin
              cmd.item_load = 1'b1;
              final_nxt     = (in_op == svs_pkg::OP_FINAL);
              state_nxt     = S_LOAD;
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd.joint_load = 1'b1;
        step_nxt       = '0;
        vec_nxt        = '0;
        state_nxt      = S_RUN;
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (step_r == svs_pkg::LAST_STEP) begin
          step_nxt = '0;
          vec_nxt  = vec_r + 2'd1;
          if (vec_r == svs_pkg::LAST_VEC) begin
            state_nxt = final_r ? S_EMIT : S_IDLE;
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      vec_r       <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      vec_r       <= vec_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while held");

  a_weight_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.item_load |=> (state_r == S_LOAD))
    else $error("weight item did not start joint load");

  a_run_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> (state_r == S_RUN && step_r == 4'd0 && vec_r == 2'd0))
    else $error("sequence did not start at first step");

endmodule

### rtl/svs_dp.sv
// Datapath: joint table, rotation and accumulation arithmetic, output register.
module svs_dp #(
  parameter int MAX_JOINTS = svs_pkg::MAX_JOINTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  svs_pkg::in_t  in_data,
  input  svs_pkg::cmd_t cmd,
  output svs_pkg::out_t out_data
);

  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic [AW+5:0]               idx_ext;
  logic [AW-1:0]               addr;
  logic                        idx_ok;
  logic [svs_pkg::JT_W-1:0]    wdata, rdata;

  assign idx_ext = {{AW{1'b0}}, in_data.joint_index};
  assign addr    = idx_ext[AW-1:0];
  assign idx_ok  = idx_ext < (AW+6)'(MAX_JOINTS);
  assign wdata   = {in_data.vec_a_x, in_data.vec_a_y, in_data.vec_a_z,
                    in_data.vec_b_x, in_data.vec_b_y, in_data.vec_b_z,
                    in_data.scalar_value};

  svs_ram #(.WIDTH(svs_pkg::JT_W), .DEPTH(MAX_JOINTS), .AW(AW)) u_jt (
    .clk   (clk),
    .we    (cmd.joint_write && idx_ok),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  logic signed [31:0] wpos_r [3];
  logic signed [31:0] bias_r;
  logic               jvalid_r;
  logic signed [31:0] q_r [4];
  logic signed [31:0] jp_r [3];
  logic signed [31:0] basis_r [9];
  logic signed [47:0] acc_r [12];
  logic signed [63:0] prod_r [3];
  logic signed [31:0] a_r [3];
  logic signed [31:0] t_r [3];
  logic signed [31:0] c_r [3];
  logic signed [31:0] term_r [3];
  svs_pkg::out_t      out_r;

  logic signed [31:0] v [3];
  logic signed [31:0] ma [3];
  logic signed [31:0] mb [3];

  always_comb begin
    int j1, j2;
    for (int i = 0; i < 3; i++) begin
      case (cmd.vsel)
        2'd0:    v[i] = wpos_r[i];
        2'd1:    v[i] = basis_r[i];
        2'd2:    v[i] = basis_r[3+i];
        default: v[i] = basis_r[6+i];
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      j1 = (i == 2) ? 0 : i + 1;
      j2 = (i == 0) ? 2 : i - 1;
      case (cmd.step)
        svs_pkg::ST_X0:  begin ma[i] = q_r[j1];    mb[i] = v[j2];   end
        svs_pkg::ST_X1:  begin ma[i] = q_r[j2];    mb[i] = v[j1];   end
        svs_pkg::ST_Y0:  begin ma[i] = q_r[j1];    mb[i] = t_r[j2]; end
        svs_pkg::ST_Y1:  begin ma[i] = q_r[j2];    mb[i] = t_r[j1]; end
        svs_pkg::ST_C:   begin ma[i] = q_r[3];     mb[i] = t_r[i];  end
        svs_pkg::ST_MUL: begin ma[i] = term_r[i];  mb[i] = bias_r;  end
        default:         begin ma[i] = '0;         mb[i] = '0;      end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    logic signed [35:0] d;
    logic signed [31:0] r;
    logic signed [63:0] p;
    logic signed [48:0] s;
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= ma[i] * mb[i];
    end
    if (cmd.item_load) begin
      wpos_r[0] <= in_data.vec_a_x;
      wpos_r[1] <= in_data.vec_a_y;
      wpos_r[2] <= in_data.vec_a_z;
      bias_r    <= in_data.scalar_value;
      jvalid_r  <= idx_ok;
    end
    if (cmd.joint_load) begin
      // entries beyond the table read as a zero joint
      jp_r[0] <= jvalid_r ? rdata[223:192] : '0;
      jp_r[1] <= jvalid_r ? rdata[191:160] : '0;
      jp_r[2] <= jvalid_r ? rdata[159:128] : '0;
      q_r[0]  <= jvalid_r ? rdata[127:96]  : '0;
      q_r[1]  <= jvalid_r ? rdata[95:64]   : '0;
      q_r[2]  <= jvalid_r ? rdata[63:32]   : '0;
      q_r[3]  <= jvalid_r ? rdata[31:0]    : '0;
    end
    if (cmd.run) begin
      for (int i = 0; i < 3; i++) begin
        case (cmd.step)
          svs_pkg::ST_X1, svs_pkg::ST_Y1: a_r[i] <= svs_pkg::qmul(prod_r[i]);
          svs_pkg::ST_T: begin
            d = 36'(a_r[i]) - 36'(svs_pkg::qmul(prod_r[i]));
            r = svs_pkg::sat32(d);
            t_r[i] <= svs_pkg::sat32(36'(r) + 36'(r));
          end
          svs_pkg::ST_C: begin
            c_r[i] <= svs_pkg::sat32(36'(a_r[i]) - 36'(svs_pkg::qmul(prod_r[i])));
          end
          svs_pkg::ST_SUM: begin
            d = 36'(v[i]) + 36'(svs_pkg::qmul(prod_r[i])) + 36'(c_r[i]);
            r = svs_pkg::sat32(d);
            term_r[i] <= (cmd.vsel == 2'd0) ? svs_pkg::sat32(36'(jp_r[i]) + 36'(r)) : r;
          end
          default: ;
        endcase
      end
    end
    if (cmd.out_load) begin
      out_r.pos_x   <= svs_pkg::sat48to32(acc_r[0]);
      out_r.pos_y   <= svs_pkg::sat48to32(acc_r[1]);
      out_r.pos_z   <= svs_pkg::sat48to32(acc_r[2]);
      out_r.norm_x  <= svs_pkg::sat48to32(acc_r[3]);
      out_r.norm_y  <= svs_pkg::sat48to32(acc_r[4]);
      out_r.norm_z  <= svs_pkg::sat48to32(acc_r[5]);
      out_r.tan_x   <= svs_pkg::sat48to32(acc_r[6]);
      out_r.tan_y   <= svs_pkg::sat48to32(acc_r[7]);
      out_r.tan_z   <= svs_pkg::sat48to32(acc_r[8]);
      out_r.bitan_x <= svs_pkg::sat48to32(acc_r[9]);
      out_r.bitan_y <= svs_pkg::sat48to32(acc_r[10]);
      out_r.bitan_z <= svs_pkg::sat48to32(acc_r[11]);
    end
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) basis_r[k] <= '0;
      for (int k = 0; k < 12; k++) acc_r[k] <= '0;
    end else if (cmd.basis_load) begin
      basis_r[0] <= in_data.vec_a_x;
      basis_r[1] <= in_data.vec_a_y;
      basis_r[2] <= in_data.vec_a_z;
      basis_r[3] <= in_data.vec_b_x;
      basis_r[4] <= in_data.vec_b_y;
      basis_r[5] <= in_data.vec_b_z;
      basis_r[6] <= in_data.vec_c_x;
      basis_r[7] <= in_data.vec_c_y;
      basis_r[8] <= in_data.vec_c_z;
      for (int k = 0; k < 12; k++) acc_r[k] <= '0;
    end else if (cmd.run && cmd.step == svs_pkg::ST_ACC) begin
      for (int i = 0; i < 3; i++) begin
        p = (prod_r[i] + 64'sd32768) >>> 16;
        s = 49'(acc_r[3*cmd.vsel+i]) + p[48:0];
        if (s > 49'sd140737488355327) acc_r[3*cmd.vsel+i] <= 48'sh7fffffffffff;
        else if (s < -49'sd140737488355328) acc_r[3*cmd.vsel+i] <= 48'sh800000000000;
        else acc_r[3*cmd.vsel+i] <= s[47:0];
      end
    end
  end

  assign out_data = out_r;

endmodule

### rtl/skeletal_vertex_skinning_top.sv
// Top level of the linear blend skinning block.
// Usage:
//   One input channel (in_valid/in_ready/in_data) carries four kinds of item:
//   joint write, vertex start, weight, and final weight of a vertex.
//   Joint writes and vertex starts produce nothing and leave the block idle.
//   A weight item first loads the joint read from the table, then runs
//   nine steps for each of four vectors (weight position, normal, tangent,
//   bitangent) through three shared 32x32 multipliers. A final-weight item
//   then passes an emit state, which loads the skinned vertex into the
//   output register (out_valid/out_ready/out_data).
//   The block takes one item at a time; in_ready is high while it is idle.
//   A held result does not block input: if the receiver stalls, the next
//   final weight waits in its emit state until the output register frees.
//   Reset clears the control state, the bind basis and the accumulators;
//   the joint table holds no defined value until each entry is written.
module skeletal_vertex_skinning_top #(
  parameter int MAX_JOINTS = svs_pkg::MAX_JOINTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  svs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output svs_pkg::out_t out_data
);

  svs_pkg::cmd_t cmd;

  svs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  svs_dp #(.MAX_JOINTS(MAX_JOINTS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
